@@ src/pdmad_pkg.sv @@
// Shared types and constants for the PWM duty meter with averaging DAC output.
// Holds the controller-to-datapath command and status structs and the fixed field codes.
// No dependencies.
package pdmad_pkg;

   // Fixed field widths of the result channel.
   localparam int DUTY_BITS = 7;
   localparam int DAC_BITS  = 10;

   // Every division in the block yields a quotient of at most ten bits.
   localparam int QUOT_BITS = 10;
   localparam int STEP_BITS = 4;

   // Arithmetic constants.
   localparam int DUTY_FULL = 100;

   // Input mode codes.
   localparam logic MODE_EDGE = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   // Result kind codes.
   localparam logic RESULT_DUTY = 1'b0;
   localparam logic RESULT_DAC  = 1'b1;

   typedef struct packed {
      logic edge_first;   // first edge: capture rising time
      logic edge_fall;    // falling edge: capture high time
      logic edge_period;  // closing rising edge: capture period, restart rising time
      logic duty_start;   // check period and high time, start the duty division
      logic div_step;     // one restoring division step
      logic sum_clear;    // start a sweep over the duty ring
      logic sum_step;     // one step of the sweep
      logic avg_load;     // divide the ring sum by the sample count
      logic code_load;    // scale the average to a DAC code
      logic duty_store;   // write the duty to the ring and the result register
      logic tick_out;     // write the DAC code to the result register
   } pdmad_cmd_type;

   typedef struct packed {
      logic period_zero;
      logic high_ge;
      logic div_last;
      logic sum_last;
   } pdmad_sts_type;

endpackage

@@ src/pdmad_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pdmad_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/pdmad_dpath.sv @@
// Datapath of the PWM duty meter: edge time registers, duty ring, ten-step
// restoring divider for the duty, ring sum, reciprocal-multiply average and
// DAC scaling, and result register. Depends on pdmad_pkg and pdmad_ram.
module pdmad_dpath #(
   parameter int SAMPLE_COUNT = 10,
   parameter int STAMP_BITS   = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [31:0]               req_stamp,
   input  pdmad_pkg::pdmad_cmd_type  cmd,
   output pdmad_pkg::pdmad_sts_type  sts,
   output logic                      rsp_result_kind,
   output logic [6:0]                rsp_duty_percent,
   output logic [9:0]                rsp_dac_code
);
   import pdmad_pkg::*;

   localparam int TAKE_BITS = (STAMP_BITS < 32) ? STAMP_BITS : 32;
   localparam int REM_W     = STAMP_BITS + QUOT_BITS;
   localparam int IDX_W     = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
   localparam int CNT_W     = $clog2(SAMPLE_COUNT + 1);
   localparam int SUM_W     = $clog2(SAMPLE_COUNT * DUTY_FULL + 1);

   // Division by a constant through a rounded-up reciprocal; the shift covers the
   // operand width plus the divisor width, which keeps the quotient exact.
   localparam int AVG_SHIFT   = SUM_W + $clog2(SAMPLE_COUNT);
   localparam int AVG_MUL     = ((1 << AVG_SHIFT) + SAMPLE_COUNT - 1) / SAMPLE_COUNT;
   localparam int AVG_MUL_W   = SUM_W + 2;
   localparam int AVG_PROD_W  = SUM_W + AVG_MUL_W;
   localparam int DAC_FULL    = (1 << DAC_BITS) - 1;
   localparam int CODE_X_W    = $clog2(DUTY_FULL * DAC_FULL + 1);
   localparam int CODE_SHIFT  = CODE_X_W + $clog2(DUTY_FULL);
   localparam int CODE_MUL    = ((1 << CODE_SHIFT) + DUTY_FULL - 1) / DUTY_FULL;
   localparam int CODE_MUL_W  = CODE_X_W + 2;
   localparam int CODE_PROD_W = CODE_X_W + CODE_MUL_W;

   logic [STAMP_BITS-1:0] stamp_w;
   logic [STAMP_BITS-1:0] stamp_diff;

   logic [STAMP_BITS-1:0] rising_ff, rising_in;
   logic [STAMP_BITS-1:0] high_ff, high_in;
   logic [STAMP_BITS-1:0] period_ff, period_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [REM_W-1:0]      dsh_ff, dsh_in;
   logic [QUOT_BITS-1:0]  quot_ff, quot_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [CNT_W-1:0]      rd_cnt_ff, rd_cnt_in;
   logic                  rd_pend_ff, rd_pend_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [SAMPLE_COUNT-1:0] valid_ff, valid_in;
   logic [IDX_W-1:0]      slot_ff, slot_in;
   logic                  kind_ff, kind_in;
   logic [DUTY_BITS-1:0]  duty_ff, duty_in;
   logic [DAC_BITS-1:0]   dac_ff, dac_in;

   logic                  rd_active;
   logic [IDX_W-1:0]      rd_addr;
   logic [DUTY_BITS-1:0]  rd_data;
   logic [REM_W-1:0]      high_x100;
   logic [DUTY_BITS-1:0]  avg;
   logic [AVG_PROD_W-1:0] avg_prod;
   logic [CODE_X_W-1:0]   code_x;
   logic [CODE_PROD_W-1:0] code_prod;

   assign stamp_w    = STAMP_BITS'(req_stamp[TAKE_BITS-1:0]);
   assign stamp_diff = stamp_w - rising_ff;
   assign high_x100  = (REM_W'(high_ff) << 6) + (REM_W'(high_ff) << 5)
                       + (REM_W'(high_ff) << 2);
   assign avg        = quot_ff[DUTY_BITS-1:0];
   assign rd_active  = rd_cnt_ff < CNT_W'(SAMPLE_COUNT);
   assign rd_addr    = rd_active ? rd_cnt_ff[IDX_W-1:0] : '0;

   // avg * 1023 is avg * 1024 - avg.
   assign avg_prod   = AVG_PROD_W'(sum_ff) * AVG_PROD_W'(AVG_MUL);
   assign code_x     = (CODE_X_W'(avg) << DAC_BITS) - CODE_X_W'(avg);
   assign code_prod  = CODE_PROD_W'(code_x) * CODE_PROD_W'(CODE_MUL);

   pdmad_ram #(
      .WIDTH(DUTY_BITS),
      .DEPTH(SAMPLE_COUNT)
   ) u_ring (
      .clock  (clock),
      .wr_en  (cmd.duty_store),
      .wr_addr(slot_ff),
      .wr_data(quot_ff[DUTY_BITS-1:0]),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      rising_in  = rising_ff;
      high_in    = high_ff;
      period_in  = period_ff;
      rem_in     = rem_ff;
      dsh_in     = dsh_ff;
      quot_in    = quot_ff;
      step_in    = step_ff;
      sum_in     = sum_ff;
      rd_cnt_in  = rd_cnt_ff;
      rd_pend_in = 1'b0;
      rd_vld_in  = valid_ff[rd_addr];
      valid_in   = valid_ff;
      slot_in    = slot_ff;
      kind_in    = kind_ff;
      duty_in    = duty_ff;
      dac_in     = dac_ff;

      if (cmd.edge_first) begin
         rising_in = stamp_w;
      end
      if (cmd.edge_fall) begin
         high_in = stamp_diff;
      end
      if (cmd.edge_period) begin
         period_in = stamp_diff;
         rising_in = stamp_w;
      end

      if (cmd.duty_start) begin
         quot_in = '0;
         if (period_ff == '0) begin
            quot_in = '0;
         end else if (high_ff >= period_ff) begin
            quot_in = QUOT_BITS'(DUTY_FULL);
         end else begin
            rem_in  = high_x100;
            dsh_in  = REM_W'(period_ff) << (QUOT_BITS - 1);
            step_in = STEP_BITS'(QUOT_BITS - 1);
         end
      end
      if (cmd.avg_load) begin
         quot_in = QUOT_BITS'(avg_prod >> AVG_SHIFT);
      end
      if (cmd.code_load) begin
         quot_in = QUOT_BITS'(code_prod >> CODE_SHIFT);
      end
      if (cmd.div_step) begin
         if (rem_ff >= dsh_ff) begin
            rem_in  = rem_ff - dsh_ff;
            quot_in = {quot_ff[QUOT_BITS-2:0], 1'b1};
         end else begin
            quot_in = {quot_ff[QUOT_BITS-2:0], 1'b0};
         end
         dsh_in  = dsh_ff >> 1;
         step_in = step_ff - 1'b1;
      end

      // Read data arrives in the cycle after its address; an unwritten entry adds zero.
      if (cmd.sum_clear) begin
         sum_in    = '0;
         rd_cnt_in = '0;
      end
      if (cmd.sum_step) begin
         rd_pend_in = rd_active;
         if (rd_active) begin
            rd_cnt_in = rd_cnt_ff + 1'b1;
         end
         if (rd_pend_ff && rd_vld_ff) begin
            sum_in = sum_ff + SUM_W'(rd_data);
         end
      end

      if (cmd.duty_store) begin
         valid_in[slot_ff] = 1'b1;
         if (slot_ff == IDX_W'(SAMPLE_COUNT - 1)) begin
            slot_in = '0;
         end else begin
            slot_in = slot_ff + 1'b1;
         end
         kind_in = RESULT_DUTY;
         duty_in = quot_ff[DUTY_BITS-1:0];
         dac_in  = '0;
      end
      if (cmd.tick_out) begin
         kind_in = RESULT_DAC;
         duty_in = '0;
         dac_in  = quot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rising_ff  <= '0;
         high_ff    <= '0;
         valid_ff   <= '0;
         slot_ff    <= '0;
         step_ff    <= '0;
         rd_cnt_ff  <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         rising_ff  <= rising_in;
         high_ff    <= high_in;
         valid_ff   <= valid_in;
         slot_ff    <= slot_in;
         step_ff    <= step_in;
         rd_cnt_ff  <= rd_cnt_in;
         rd_pend_ff <= rd_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      period_ff <= period_in;
      rem_ff    <= rem_in;
      dsh_ff    <= dsh_in;
      quot_ff   <= quot_in;
      sum_ff    <= sum_in;
      rd_vld_ff <= rd_vld_in;
      kind_ff   <= kind_in;
      duty_ff   <= duty_in;
      dac_ff    <= dac_in;
   end

   assign sts.period_zero = (period_ff == '0);
   assign sts.high_ge     = (high_ff >= period_ff);
   assign sts.div_last    = (step_ff == '0);
   assign sts.sum_last    = !rd_active;

   assign rsp_result_kind  = kind_ff;
   assign rsp_duty_percent = duty_ff;
   assign rsp_dac_code     = dac_ff;

endmodule

@@ src/pdmad_ctrl.sv @@
// Controller of the PWM duty meter: edge phase tracking, sequencing of the
// datapath and the result channel handshake.
// Depends on pdmad_pkg.
module pdmad_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_mode,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output pdmad_pkg::pdmad_cmd_type  cmd,
   input  pdmad_pkg::pdmad_sts_type  sts
);
   import pdmad_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DUTY_CHK,
      ST_DUTY_DIV,
      ST_DUTY_OUT,
      ST_SUM,
      ST_AVG_LOAD,
      ST_CODE_LOAD,
      ST_TICK_OUT
   } state_type;

   typedef enum logic [1:0] {
      PH_NONE,
      PH_RISEN,
      PH_FELL
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_mode == MODE_TICK) begin
                  cmd.sum_clear = 1'b1;
                  state_in      = ST_SUM;
               end else begin
                  case (phase_ff)
                     PH_RISEN: begin
                        cmd.edge_fall = 1'b1;
                        phase_in      = PH_FELL;
                     end
                     PH_FELL: begin
                        cmd.edge_period = 1'b1;
                        phase_in        = PH_RISEN;
                        state_in        = ST_DUTY_CHK;
                     end
                     default: begin
                        cmd.edge_first = 1'b1;
                        phase_in       = PH_RISEN;
                     end
                  endcase
               end
            end
         end
         ST_DUTY_CHK: begin
            cmd.duty_start = 1'b1;
            if (sts.period_zero || sts.high_ge) begin
               state_in = ST_DUTY_OUT;
            end else begin
               state_in = ST_DUTY_DIV;
            end
         end
         ST_DUTY_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_DUTY_OUT;
            end
         end
         ST_DUTY_OUT: begin
            if (out_free) begin
               cmd.duty_store = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_SUM: begin
            cmd.sum_step = 1'b1;
            if (sts.sum_last) begin
               state_in = ST_AVG_LOAD;
            end
         end
         ST_AVG_LOAD: begin
            cmd.avg_load = 1'b1;
            state_in     = ST_CODE_LOAD;
         end
         ST_CODE_LOAD: begin
            cmd.code_load = 1'b1;
            state_in      = ST_TICK_OUT;
         end
         ST_TICK_OUT: begin
            if (out_free) begin
               cmd.tick_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   // A tick leaves the edge phase alone.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_mode == MODE_TICK) |=> $stable(phase_ff))
      else $error("edge phase changed by a tick");

   // An edge that closes a period always starts a duty computation.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_mode == MODE_EDGE && phase_ff == PH_FELL)
      |=> (state_ff == ST_DUTY_CHK && phase_ff == PH_RISEN))
      else $error("period edge did not start a duty computation");

   // The result register is only overwritten once its transaction has gone.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.duty_store || cmd.tick_out) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while still pending");

   // A result is only loaded on the way back to idle.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.duty_store || cmd.tick_out) |=> (state_ff == ST_IDLE && rsp_valid_ff))
      else $error("result load did not return to idle with a valid result");
`endif

endmodule

@@ src/pwm_duty_meter_averaging_dac_unit.sv @@
// PWM duty meter with a moving-average DAC output. An edge transaction that opens a
// period or marks the falling edge is taken in the idle state alone; an edge that
// closes a period goes through the period check and then straight to the output
// (zero period or saturated duty) or through the ten-step restoring divider for the
// duty first. A tick transaction sweeps the duty ring through its single read port,
// then computes the average and the scaling to the 10-bit code, each in its own
// state and both by reciprocal multiplication. One transaction is worked on at a
// time; a finished result waits until the output register is free to take it, and
// the block then returns to accepting input while that result is offered.
// Depends on pdmad_pkg, pdmad_ctrl, pdmad_dpath and pdmad_ram.
module pwm_duty_meter_averaging_dac_unit #(
   parameter int SAMPLE_COUNT = 10,
   parameter int STAMP_BITS   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [31:0] req_stamp,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic [6:0]  rsp_duty_percent,
   output logic [9:0]  rsp_dac_code
);
   import pdmad_pkg::*;

   pdmad_cmd_type cmd;
   pdmad_sts_type sts;

   pdmad_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode (req_mode),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .cmd      (cmd),
      .sts      (sts)
   );

   pdmad_dpath #(
      .SAMPLE_COUNT(SAMPLE_COUNT),
      .STAMP_BITS  (STAMP_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_stamp       (req_stamp),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_result_kind (rsp_result_kind),
      .rsp_duty_percent(rsp_duty_percent),
      .rsp_dac_code    (rsp_dac_code)
   );

endmodule
